### rtl/svalloc_pkg.sv
// ----------------------------------------------------------------------------
// svalloc_pkg - shared types and codes of the synth voice allocator
// Voice bank size, request and register codes, per-voice vector types.
// ----------------------------------------------------------------------------
package svalloc_pkg;

    localparam int NUM_VOICES    = 8;
    localparam int UNISON_VOICES = 4;
    localparam int MASK_W        = 8;

    localparam int UNI_COUNT = (UNISON_VOICES < NUM_VOICES) ? UNISON_VOICES : NUM_VOICES;

    // request op codes
    localparam logic [1:0] OP_NOTE_ON    = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF   = 2'd1;
    localparam logic [1:0] OP_VOICE_DONE = 2'd2;

    // voice_mode codes
    localparam logic [1:0] MODE_MONO   = 2'd0;
    localparam logic [1:0] MODE_POLY   = 2'd1;
    localparam logic [1:0] MODE_UNISON = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VOICE_MODE  = 2'd0;
    localparam logic [1:0] CFG_NOTE_ENABLE = 2'd1;

    localparam logic [7:0] NOTE_NONE = 8'd128;
    localparam logic [7:0] AGE_MAX   = 8'd255;

    typedef logic [NUM_VOICES-1:0]       t_vmask;
    typedef logic [NUM_VOICES-1:0][7:0]  t_age_vec;
    typedef logic [NUM_VOICES-1:0][6:0]  t_note_vec;

    localparam t_vmask UNI_MASK = t_vmask'((64'd1 << UNI_COUNT) - 64'd1);

    typedef struct packed {
        logic   free_found;
        t_vmask target;
    } t_pick;

    // isolate the lowest set bit
    function automatic t_vmask lowest_bit(input t_vmask v);
        return v & (~v + t_vmask'(1));
    endfunction

endpackage

### rtl/svalloc_pick.sv
// ----------------------------------------------------------------------------
// svalloc_pick - poly mode target selection
// Lowest free voice, else the oldest voice (lowest index on equal age).
// ----------------------------------------------------------------------------
module svalloc_pick
    import svalloc_pkg::*;
(
    input  t_vmask   i_active,
    input  t_age_vec i_age,
    output t_pick    o_pick
);

    t_vmask     free_oh;
    t_vmask     oldest_oh;
    logic [7:0] best_age;

    always_comb begin
        free_oh   = lowest_bit(~i_active);
        best_age  = i_age[0];
        oldest_oh = t_vmask'(1);
        // strict compare keeps the lowest index on a tie
        for (int i = 1; i < NUM_VOICES; i++) begin
            if (i_age[i] > best_age) begin
                best_age  = i_age[i];
                oldest_oh = t_vmask'(1) << i;
            end
        end
        o_pick.free_found = (free_oh != '0);
        o_pick.target     = (free_oh != '0) ? free_oh : oldest_oh;
    end

endmodule

### rtl/synth_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// synth_voice_allocator_core - polyphonic voice allocation with stealing
// Pipeline: a request is taken into the input register, then the
//   allocation logic writes its result into the result register.
// Throughput: one request per cycle unless the output stalls; the voice
//   state is read and rewritten as requests fire back to back.
// Reset: synchronous, active low; all voices idle, last note none, poly mode,
//   notes enabled. No clearing pass is needed.
// ----------------------------------------------------------------------------
module synth_voice_allocator_core
    import svalloc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // configuration write port
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [1:0]        i_cfg_data,

    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [6:0]        i_note,
    input  logic [6:0]        i_velocity,
    input  logic [2:0]        i_voice,

    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_started_mask,
    output logic [MASK_W-1:0] o_steal_mask,
    output logic [MASK_W-1:0] o_released_mask,
    output logic [MASK_W-1:0] o_stopped_mask,
    output logic [6:0]        o_out_note,
    output logic [6:0]        o_out_velocity,
    output logic [7:0]        o_prev_note,
    output logic              o_dropped
);

    // configuration
    logic [1:0] r_mode;
    logic       r_enable;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [6:0] r_in_note;
    logic [6:0] r_in_vel;
    logic [2:0] r_in_voice;

    // voice state
    t_vmask     r_active, n_active;
    t_vmask     r_held,   n_held;
    t_vmask     r_pend,   n_pend;
    t_note_vec  r_vnote,  n_vnote;
    t_note_vec  r_snote,  n_snote;
    t_note_vec  r_svel,   n_svel;
    t_age_vec   r_age,    n_age;
    logic [7:0] r_last,   n_last;

    // result register
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_start, r_out_steal, r_out_rel, r_out_stop;
    logic [6:0]        r_out_note, r_out_vel;
    logic [7:0]        r_out_prev;
    logic              r_out_drop;

    // combinational result
    t_vmask     n_start, n_steal, n_rel, n_stop;
    logic [6:0] n_onote, n_ovel;
    logic [7:0] n_prev;
    logic       n_drop;

    t_vmask     deliver_mask;
    t_vmask     off_note_hit, off_steal_hit, off_hit;
    t_pick      pick;
    logic       fire;

    // ------------------------------------------------------------------
    // Handshake: the allocation stage fires when the result register is
    // empty or being drained; the input register refills in the same cycle.
    // ------------------------------------------------------------------
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    svalloc_pick u_pick (
        .i_active (r_active),
        .i_age    (r_age),
        .o_pick   (pick)
    );

    // ------------------------------------------------------------------
    // Allocation logic
    // ------------------------------------------------------------------
    always_comb begin
        n_active = r_active;
        n_held   = r_held;
        n_pend   = r_pend;
        n_vnote  = r_vnote;
        n_snote  = r_snote;
        n_svel   = r_svel;
        n_age    = r_age;
        n_last   = r_last;
        n_start  = '0;
        n_steal  = '0;
        n_rel    = '0;
        n_stop   = '0;
        n_onote  = '0;
        n_ovel   = '0;
        n_prev   = NOTE_NONE;
        n_drop   = 1'b0;

        // voices that take a note on in the current mode
        case (r_mode)
            MODE_MONO:   deliver_mask = t_vmask'(1);
            MODE_POLY:   deliver_mask = pick.target;
            MODE_UNISON: deliver_mask = UNI_MASK;
            default:     deliver_mask = '0;
        endcase

        // note off matches in poly mode: held note first, then pending steal
        off_note_hit  = '0;
        off_steal_hit = '0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            off_note_hit[i]  = r_active[i] && r_held[i] && (r_vnote[i] == r_in_note);
            off_steal_hit[i] = r_active[i] && r_held[i] && r_pend[i]
                               && (r_snote[i] == r_in_note);
        end
        off_hit = (off_note_hit != '0) ? lowest_bit(off_note_hit)
                                       : lowest_bit(off_steal_hit);

        if (r_in_op == OP_NOTE_ON && r_enable) begin
            n_prev  = r_last;
            n_onote = r_in_note;
            n_ovel  = r_in_vel;
            for (int i = 0; i < NUM_VOICES; i++) begin
                if (deliver_mask[i]) begin
                    n_age[i] = '0;
                    if (r_active[i]) begin
                        // queue over a busy voice, overwriting any earlier queue
                        n_pend[i]  = 1'b1;
                        n_snote[i] = r_in_note;
                        n_svel[i]  = r_in_vel;
                        n_steal[i] = 1'b1;
                    end else begin
                        n_active[i] = 1'b1;
                        n_held[i]   = 1'b1;
                        n_vnote[i]  = r_in_note;
                        n_start[i]  = 1'b1;
                    end
                end
            end
            // poly: age every voice that is now active
            if (r_mode == MODE_POLY) begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (n_active[i] && n_age[i] != AGE_MAX) begin
                        n_age[i] = n_age[i] + 8'd1;
                    end
                end
            end
            n_last = {1'b0, r_in_note};
        end else if (r_in_op == OP_NOTE_OFF && r_enable) begin
            case (r_mode)
                MODE_MONO:   n_rel = r_active & t_vmask'(1);
                MODE_POLY: begin
                    n_rel = off_hit;
                    // a match on the queued note cancels the queue
                    if (off_note_hit == '0) begin
                        n_pend = r_pend & ~off_hit;
                    end
                end
                MODE_UNISON: n_rel = r_active & UNI_MASK;
                default:     n_rel = '0;
            endcase
            n_held = n_held & ~n_rel;
            if (r_mode inside {MODE_MONO, MODE_POLY, MODE_UNISON}) begin
                if (n_rel != '0) begin
                    n_onote = r_in_note;
                    n_ovel  = r_in_vel;
                end else begin
                    n_drop = 1'b1;
                end
            end
        end else if (r_in_op == OP_VOICE_DONE) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                if (i == int'(r_in_voice) && r_active[i]) begin
                    if (r_pend[i]) begin
                        // start the queued note
                        n_pend[i]  = 1'b0;
                        n_vnote[i] = r_snote[i];
                        n_held[i]  = 1'b1;
                        n_start[i] = 1'b1;
                        n_onote    = r_snote[i];
                        n_ovel     = r_svel[i];
                    end else begin
                        n_active[i] = 1'b0;
                        n_held[i]   = 1'b0;
                        n_stop[i]   = 1'b1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_POLY;
            r_enable    <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_held      <= '0;
            r_pend      <= '0;
            r_vnote     <= '0;
            r_snote     <= '0;
            r_svel      <= '0;
            r_age       <= '0;
            r_last      <= NOTE_NONE;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_VOICE_MODE) begin
                    r_mode <= i_cfg_data;
                end
                if (i_cfg_index == CFG_NOTE_ENABLE) begin
                    r_enable <= i_cfg_data[0];
                end
            end

            // input register: hold while stalled, load on acceptance
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end

            if (fire) begin
                r_active <= n_active;
                r_held   <= n_held;
                r_pend   <= n_pend;
                r_vnote  <= n_vnote;
                r_snote  <= n_snote;
                r_svel   <= n_svel;
                r_age    <= n_age;
                r_last   <= n_last;
            end

            // result register: drop once taken, refill on fire
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_op    <= i_op;
            r_in_note  <= i_note;
            r_in_vel   <= i_velocity;
            r_in_voice <= i_voice;
        end
        if (fire) begin
            r_out_start <= MASK_W'(n_start);
            r_out_steal <= MASK_W'(n_steal);
            r_out_rel   <= MASK_W'(n_rel);
            r_out_stop  <= MASK_W'(n_stop);
            r_out_note  <= n_onote;
            r_out_vel   <= n_ovel;
            r_out_prev  <= n_prev;
            r_out_drop  <= n_drop;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_started_mask  = r_out_start;
    assign o_steal_mask    = r_out_steal;
    assign o_released_mask = r_out_rel;
    assign o_stopped_mask  = r_out_stop;
    assign o_out_note      = r_out_note;
    assign o_out_velocity  = r_out_vel;
    assign o_prev_note     = r_out_prev;
    assign o_dropped       = r_out_drop;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pend_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_active) == '0)
        else $error("steal queued on an idle voice");

    a_held_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held & ~r_active) == '0)
        else $error("idle voice marked as held");

    a_free_poly_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_enable && r_mode == MODE_POLY && r_in_op == OP_NOTE_ON
        && pick.free_found |=> o_out_valid
        && ($onehot(o_started_mask) || NUM_VOICES > MASK_W))
        else $error("poly note on with a free voice started no single voice");

    a_start_stop_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_started_mask & o_stopped_mask) == '0)
        else $error("voice both started and stopped by one request");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("allocation result lost");

endmodule

### sim/svalloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svalloc_checker - result checker for the synth voice allocator core
// Follows the configuration port and both channels. Predicts the result of
// each accepted request and compares every result with the oldest one due.
// ----------------------------------------------------------------------------
module svalloc_checker
    import svalloc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [1:0]        i_cfg_data,

    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_op,
    input  logic [6:0]        i_note,
    input  logic [6:0]        i_velocity,
    input  logic [2:0]        i_voice,

    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [MASK_W-1:0] i_started_mask,
    input  logic [MASK_W-1:0] i_steal_mask,
    input  logic [MASK_W-1:0] i_released_mask,
    input  logic [MASK_W-1:0] i_stopped_mask,
    input  logic [6:0]        i_out_note,
    input  logic [6:0]        i_out_velocity,
    input  logic [7:0]        i_prev_note,
    input  logic              i_dropped,

    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_steals,
    output int                o_drops
);

    typedef struct packed {
        logic [MASK_W-1:0] started;
        logic [MASK_W-1:0] steal;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] stopped;
        logic [6:0]        note;
        logic [6:0]        velocity;
        logic [7:0]        prev;
        logic              dropped;
    } t_alloc_result;

    // shadow configuration and voice bank
    logic [1:0]    voice_mode;
    logic          notes_on;
    t_vmask        v_active;
    t_vmask        v_held;
    t_vmask        queued;
    t_note_vec     v_note;
    t_note_vec     queued_note;
    t_note_vec     queued_vel;
    t_age_vec      v_age;
    logic [7:0]    last_note;

    t_alloc_result due_q[$];

    // hand a note on to one voice: start it when idle, else queue the note
    task automatic hand_note(input int v, input logic [6:0] n, input logic [6:0] vel,
                             inout t_alloc_result r);
        v_age[v] = '0;
        if (v_active[v]) begin
            queued[v]      = 1'b1;
            queued_note[v] = n;
            queued_vel[v]  = vel;
            r.steal[v]     = 1'b1;
        end else begin
            v_active[v]  = 1'b1;
            v_held[v]    = 1'b1;
            v_note[v]    = n;
            r.started[v] = 1'b1;
        end
    endtask

    task automatic allocate(input logic [1:0] op, input logic [6:0] n,
                            input logic [6:0] vel, input logic [2:0] vx,
                            output t_alloc_result r);
        int target;
        int hit;
        r      = '0;
        r.prev = NOTE_NONE;
        if (op == OP_NOTE_ON && notes_on) begin
            r.prev     = last_note;
            r.note     = n;
            r.velocity = vel;
            case (voice_mode)
                MODE_MONO: begin
                    hand_note(0, n, vel, r);
                end
                MODE_POLY: begin
                    target = -1;
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (target < 0 && !v_active[i]) target = i;
                    // no free voice: take the oldest, lowest index on ties
                    if (target < 0) begin
                        target = 0;
                        for (int i = 1; i < NUM_VOICES; i++)
                            if (v_age[i] > v_age[target]) target = i;
                    end
                    hand_note(target, n, vel, r);
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (v_active[i] && v_age[i] != AGE_MAX) v_age[i] = v_age[i] + 8'd1;
                end
                MODE_UNISON: begin
                    for (int i = 0; i < UNI_COUNT; i++) hand_note(i, n, vel, r);
                end
                default: ;
            endcase
            last_note = {1'b0, n};
        end else if (op == OP_NOTE_OFF && notes_on) begin
            case (voice_mode)
                MODE_MONO: begin
                    if (v_active[0]) begin
                        v_held[0]     = 1'b0;
                        r.released[0] = 1'b1;
                    end
                end
                MODE_POLY: begin
                    hit = -1;
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (hit < 0 && v_active[i] && v_held[i] && v_note[i] == n) hit = i;
                    // fall back to a queued note, and cancel it
                    if (hit < 0) begin
                        for (int i = 0; i < NUM_VOICES; i++)
                            if (hit < 0 && v_active[i] && v_held[i] && queued[i] &&
                                queued_note[i] == n) hit = i;
                        if (hit >= 0) queued[hit] = 1'b0;
                    end
                    if (hit >= 0) begin
                        v_held[hit]     = 1'b0;
                        r.released[hit] = 1'b1;
                    end
                end
                MODE_UNISON: begin
                    for (int i = 0; i < UNI_COUNT; i++)
                        if (v_active[i]) begin
                            v_held[i]     = 1'b0;
                            r.released[i] = 1'b1;
                        end
                end
                default: ;
            endcase
            if (voice_mode <= MODE_UNISON) begin
                if (r.released != '0) begin
                    r.note     = n;
                    r.velocity = vel;
                end else begin
                    r.dropped = 1'b1;
                end
            end
        end else if (op == OP_VOICE_DONE) begin
            if (v_active[vx]) begin
                if (queued[vx]) begin
                    queued[vx]    = 1'b0;
                    v_note[vx]    = queued_note[vx];
                    v_held[vx]    = 1'b1;
                    r.started[vx] = 1'b1;
                    r.note        = queued_note[vx];
                    r.velocity    = queued_vel[vx];
                end else begin
                    v_active[vx]  = 1'b0;
                    v_held[vx]    = 1'b0;
                    r.stopped[vx] = 1'b1;
                end
            end
        end
    endtask

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result want;
        t_alloc_result got;
        if (!i_rst_n) begin
            voice_mode   = MODE_POLY;
            notes_on     = 1'b1;
            v_active     = '0;
            v_held       = '0;
            queued       = '0;
            v_note       = '0;
            queued_note  = '0;
            queued_vel   = '0;
            v_age        = '0;
            last_note    = NOTE_NONE;
            o_fail_count = 0;
            o_checked    = 0;
            o_steals     = 0;
            o_drops      = 0;
            due_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_VOICE_MODE:  voice_mode = i_cfg_data;
                    CFG_NOTE_ENABLE: notes_on   = i_cfg_data[0];
                    default: ;
                endcase
            end
            // check the result first: it can never belong to this edge's request
            if (i_out_valid && !i_out_stall) begin
                got.started  = i_started_mask;
                got.steal    = i_steal_mask;
                got.released = i_released_mask;
                got.stopped  = i_stopped_mask;
                got.note     = i_out_note;
                got.velocity = i_out_velocity;
                got.prev     = i_prev_note;
                got.dropped  = i_dropped;
                if (due_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want = due_q.pop_front();
                    cmp_field("started_mask",  want.started,  got.started);
                    cmp_field("steal_mask",    want.steal,    got.steal);
                    cmp_field("released_mask", want.released, got.released);
                    cmp_field("stopped_mask",  want.stopped,  got.stopped);
                    cmp_field("out_note",      want.note,     got.note);
                    cmp_field("out_velocity",  want.velocity, got.velocity);
                    cmp_field("prev_note",     want.prev,     got.prev);
                    cmp_field("dropped",       want.dropped,  got.dropped);
                    o_checked++;
                    if (want.steal != '0) o_steals++;
                    if (want.dropped) o_drops++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                allocate(i_op, i_note, i_velocity, i_voice, want);
                due_q.push_back(want);
            end
        end
        o_pending = due_q.size();
    end

endmodule

### sim/synth_voice_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// synth_voice_allocator_core_tb - regression bench for the voice allocator
// Drives note on, note off and voice finished requests through mono, poly,
// unison, the spare mode and notes disabled, with random gaps on both sides,
// a long result hold-off and a full drain. A checker beside the core
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module synth_voice_allocator_core_tb;
    import svalloc_pkg::*;

    localparam int         HALF_PERIOD   = 6;
    localparam int         RESET_CYCLES  = 11;
    localparam int         HOLD_CYCLES   = 250;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         RUN_LIMIT_NS  = 5_000_000;
    // codes beyond the defined ones: a spare op is a no-op; the spare mode moves no voice
    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam logic [1:0] OP_SPARE      = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [1:0]        cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        op;
    logic [6:0]        note;
    logic [6:0]        velocity;
    logic [2:0]        voice;
    logic              out_valid;
    logic              out_stall;
    logic [MASK_W-1:0] started_mask;
    logic [MASK_W-1:0] steal_mask;
    logic [MASK_W-1:0] released_mask;
    logic [MASK_W-1:0] stopped_mask;
    logic [6:0]        out_note;
    logic [6:0]        out_velocity;
    logic [7:0]        prev_note;
    logic              dropped;

    int fail_count;
    int pending;
    int checked;
    int steals;
    int drops;
    int sent = 0;

    // no_idle: both sides run flat out; hold_req: ask the receiver for a long hold-off
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;

    // notes played and not yet released, so that most note offs find a voice
    logic [6:0] played[$];

    always #(HALF_PERIOD) clk = ~clk;

    synth_voice_allocator_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (op),
        .i_note          (note),
        .i_velocity      (velocity),
        .i_voice         (voice),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_started_mask  (started_mask),
        .o_steal_mask    (steal_mask),
        .o_released_mask (released_mask),
        .o_stopped_mask  (stopped_mask),
        .o_out_note      (out_note),
        .o_out_velocity  (out_velocity),
        .o_prev_note     (prev_note),
        .o_dropped       (dropped)
    );

    svalloc_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_op            (op),
        .i_note          (note),
        .i_velocity      (velocity),
        .i_voice         (voice),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_started_mask  (started_mask),
        .i_steal_mask    (steal_mask),
        .i_released_mask (released_mask),
        .i_stopped_mask  (stopped_mask),
        .i_out_note      (out_note),
        .i_out_velocity  (out_velocity),
        .i_prev_note     (prev_note),
        .i_dropped       (dropped),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_steals        (steals),
        .o_drops         (drops)
    );

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request after a random gap and hold it until accepted.
    // Change inputs on the falling edge only; sample the stall on the rising edge.
    task automatic send_event(input logic [1:0] e_op, input logic [6:0] e_note,
                              input logic [6:0] e_vel, input logic [2:0] e_voice);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        op       = e_op;
        note     = e_note;
        velocity = e_vel;
        voice    = e_voice;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // Drop valid and wait until every result has come back, then let the
    // core's pipeline settle.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Reconfigure only with the core idle.
    task automatic set_config(input logic [1:0] mode, input logic enable);
        drain_results();
        write_reg(CFG_VOICE_MODE, mode);
        write_reg(CFG_NOTE_ENABLE, {1'b0, enable});
    endtask

    // One random request. Notes cluster in 56 to 71 so that note offs and
    // steals hit; one note in five ranges over the full field.
    task automatic random_event();
        int r;
        int k;
        logic [6:0] n;
        r = $urandom_range(0, 99);
        n = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) :
                                          7'($urandom_range(56, 71));
        if (r < 40) begin
            played.push_back(n);
            if (played.size() > 16) played.delete(0);
            send_event(OP_NOTE_ON, n, 7'($urandom()), 3'($urandom()));
        end else if (r < 70) begin
            if (played.size() > 0 && $urandom_range(0, 99) < 85) begin
                k = $urandom_range(0, played.size() - 1);
                n = played[k];
                played.delete(k);
            end
            send_event(OP_NOTE_OFF, n, 7'($urandom()), 3'($urandom()));
        end else if (r < 95) begin
            send_event(OP_VOICE_DONE, n, 7'($urandom()), 3'($urandom()));
        end else begin
            send_event(OP_SPARE, n, 7'($urandom()), 3'($urandom()));
        end
    endtask

    task automatic run_phase(input int count);
        repeat (count) random_event();
    endtask

    // Receiver: random stall runs, none while no_idle is set, and one long
    // hold-off counted here when asked for.
    initial begin
        int stall_left;
        out_stall  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req  = 1'b0;
                out_stall = 1'b0;
            end else if (no_idle || stall_left == 0) begin
                out_stall  = 1'b0;
                stall_left = no_idle ? 0 : pick_gap();
            end else begin
                out_stall = 1'b1;
                stall_left--;
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_VOICE_MODE;
        cfg_data  = MODE_POLY;
        in_valid  = 1'b0;
        op        = OP_NOTE_ON;
        note      = '0;
        velocity  = '0;
        voice     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed: poly allocation, stealing and its note off paths ---
        set_config(MODE_POLY, 1'b1);
        send_event(OP_NOTE_ON, 7'd0, 7'd0, 3'd0);           // first note: no previous
        send_event(OP_NOTE_ON, 7'd127, 7'd127, 3'd7);
        for (int i = 0; i < 6; i++)                           // fill the bank
            send_event(OP_NOTE_ON, 7'(60 + i), 7'(20 * i), 3'(i));
        send_event(OP_NOTE_ON, 7'd70, 7'd100, 3'd0);        // steal the oldest voice
        send_event(OP_NOTE_ON, 7'd71, 7'd90, 3'd0);         // steal the next oldest
        send_event(OP_NOTE_OFF, 7'd70, 7'd33, 3'd0);        // cancel a queued note
        send_event(OP_NOTE_OFF, 7'd61, 7'd44, 3'd0);        // release a held voice
        send_event(OP_NOTE_OFF, 7'd99, 7'd55, 3'd0);        // matches nothing: dropped
        send_event(OP_VOICE_DONE, 7'd0, 7'd0, 3'd0);        // finished, nothing queued
        send_event(OP_VOICE_DONE, 7'd0, 7'd0, 3'd1);        // finished, start queued note
        send_event(OP_VOICE_DONE, 7'd0, 7'd0, 3'd0);        // already idle
        send_event(OP_SPARE, 7'd127, 7'd127, 3'd7);

        // --- directed: mono with re-steal, unison, spare mode, notes off ---
        set_config(MODE_MONO, 1'b1);
        send_event(OP_NOTE_ON, 7'd40, 7'd10, 3'd0);
        send_event(OP_NOTE_ON, 7'd41, 7'd11, 3'd0);
        send_event(OP_NOTE_ON, 7'd42, 7'd12, 3'd0);         // overwrite the queued note
        send_event(OP_NOTE_OFF, 7'd5, 7'd13, 3'd0);         // any note releases voice 0
        send_event(OP_VOICE_DONE, 7'd0, 7'd0, 3'd0);
        set_config(MODE_UNISON, 1'b1);
        send_event(OP_NOTE_ON, 7'd50, 7'd64, 3'd0);
        send_event(OP_NOTE_OFF, 7'd50, 7'd64, 3'd0);
        set_config(MODE_SPARE, 1'b1);
        send_event(OP_NOTE_ON, 7'd10, 7'd20, 3'd0);
        send_event(OP_NOTE_OFF, 7'd10, 7'd20, 3'd0);
        set_config(MODE_POLY, 1'b0);
        send_event(OP_NOTE_ON, 7'd30, 7'd30, 3'd0);
        send_event(OP_NOTE_OFF, 7'd30, 7'd30, 3'd0);

        // --- random poly, with a long receiver hold-off and a full pause ---
        set_config(MODE_POLY, 1'b1);
        run_phase(50);
        hold_req = 1'b1;           // receiver holds off; keep offering flat out
        no_idle  = 1'b1;
        run_phase(40);
        no_idle  = 1'b0;
        run_phase(100);
        drain_results();           // sender pauses until nothing is outstanding
        run_phase(110);

        // --- random in the other settings ---
        set_config(MODE_MONO, 1'b1);
        run_phase(120);
        set_config(MODE_UNISON, 1'b1);
        run_phase(120);
        set_config(MODE_SPARE, 1'b1);
        run_phase(40);
        set_config(MODE_UNISON, 1'b0);
        run_phase(40);

        // --- back to poly: a stretch with no idling, then random gaps ---
        set_config(MODE_POLY, 1'b1);
        no_idle = 1'b1;
        run_phase(60);
        no_idle = 1'b0;
        run_phase(150);

        drain_results();

        $display("Covered %0d requests across mono, poly, unison, spare mode and notes off.",
                 sent);
        $display("Checked %0d results: %0d with a steal, %0d dropped note offs.",
                 checked, steals, drops);
        if (fail_count == 0 && pending == 0) begin
            $display("synth_voice_allocator_core regression: pass");
        end else begin
            $display("synth_voice_allocator_core regression: fail");
        end
        $finish;
    end

    // Hard stop if the core hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("synth_voice_allocator_core regression: fail");
        $finish;
    end

endmodule

### synth_voice_allocator_core.f
rtl/svalloc_pkg.sv
rtl/svalloc_pick.sv
rtl/synth_voice_allocator_core.sv
sim/svalloc_checker.sv
sim/synth_voice_allocator_core_tb.sv
